// ===== rtl/core/pli_pkg.sv =====
// Shared types and codes for the positional list block.
package pli_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int POS_W        = 6;
  localparam int LEN_W        = 7;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;

  localparam logic [1:0] OP_VIEW   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [LEN_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_VIEW = 2'b10
  } state_t;

endpackage

// ===== rtl/core/pli_cell.sv =====
// One list cell: holds an element and shifts in from either neighbour.
module pli_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  pli_pkg::cell_ctrl_t       ctrl,
  input  logic [pli_pkg::VAL_W-1:0] left,
  input  logic [pli_pkg::VAL_W-1:0] right,
  input  logic [pli_pkg::VAL_W-1:0] head,
  output logic [pli_pkg::VAL_W-1:0] data
);
  import pli_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      CELL_HOLD: data_next = data;
      CELL_INS: begin
        if (MY_IDX > ctrl.idx) begin
          data_next = left;
        end else if (MY_IDX == ctrl.idx) begin
          data_next = ctrl.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctrl.idx) begin
          data_next = right;
        end
      end
      CELL_ROT: begin
        if (MY_IDX == ctrl.idx) begin
          data_next = head;
        end else begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/core/positional_list_insert_delete.sv =====
// Top level of the positional list: request control and the row of cells.
//
// Requests arrive on the s_ channel: s_tuser carries the operation (view,
// insert, delete), s_tdata the position and the value. Results leave on
// the m_ channel: m_tdata carries status and element, m_tuser flags an
// empty view, m_tlast marks the final result of a request.
// Insert and delete shift the cells in a single step, and the one result
// is registered at the accepting edge. A view of n elements gives n
// results, one per cycle while the receiver accepts, by rotating the row
// of cells left once per result; after n rotations the list is back in
// order. An empty view gives one result.
// A new request is taken only while no view is streaming and the output
// register is free or being emptied, so insert and delete take one request
// per cycle while the receiver keeps up, and a view holds off new requests.
// When the receiver stalls, the output register holds and the view pauses.
// Reset empties the list and drops any pending result; cell contents are
// not cleared and are never read beyond the current length.
module positional_list_insert_delete #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero pad
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], element[33:2], zero pad
  output logic        m_tuser,   // empty_res[0]
  output logic        m_tlast
);
  import pli_pkg::*;

  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0] ONE_L = LEN_W'(1);

  state_t            state;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cnt;
  logic [ST_W-1:0]   out_status;
  logic [VAL_W-1:0]  out_element;
  logic              out_empty;

  logic [1:0]        req_op;
  logic [LEN_W-1:0]  req_pos;
  logic [VAL_W-1:0]  req_value;
  logic              out_free;
  logic              out_load;
  logic              accept;
  logic              view_step;
  logic              view_last;
  logic [ST_W-1:0]   ins_st;
  logic [ST_W-1:0]   del_st;
  logic [LEN_W-1:0]  del_idx;
  cell_ctrl_t        ctrl;
  logic [VAL_W-1:0]  cells [CAPACITY];

  assign req_op    = s_tuser;
  assign req_pos   = LEN_W'(s_tdata[POS_W-1:0]);
  assign req_value = s_tdata[POS_W +: VAL_W];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign view_step = (state == S_VIEW) && out_free;
  assign view_last = (cnt == (len - ONE_L));
  assign out_load  = view_step ||
                     (accept && ((req_op == OP_INSERT) || (req_op == OP_DELETE) ||
                                 ((req_op == OP_VIEW) && (len == '0))));

  always_comb begin
    if (req_pos > len) begin
      ins_st = ST_RANGE;
    end else if (len == CAP_L) begin
      ins_st = ST_FULL;
    end else begin
      ins_st = ST_OK;
    end
    del_st  = ((len == '0) || (req_pos > len)) ? ST_RANGE : ST_OK;
    del_idx = (req_pos == '0) ? '0 : req_pos - ONE_L;
  end

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.idx   = req_pos;
    ctrl.value = req_value;
    if (view_step) begin
      ctrl.op  = CELL_ROT;
      ctrl.idx = len - ONE_L;
    end else if (accept && (req_op == OP_INSERT) && (ins_st == ST_OK)) begin
      ctrl.op  = CELL_INS;
    end else if (accept && (req_op == OP_DELETE) && (del_st == ST_OK)) begin
      ctrl.op  = CELL_DEL;
      ctrl.idx = del_idx;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pli_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .left (cells[(i == 0) ? 0 : i - 1]),
      .right(cells[(i == CAPACITY - 1) ? i : i + 1]),
      .head (cells[0]),
      .data (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_op)
              OP_VIEW: begin
                if (len == '0) begin
                  out_status  <= ST_OK;
                  out_element <= '0;
                  m_tlast     <= 1'b1;
                  out_empty   <= 1'b1;
                end else begin
                  state <= S_VIEW;
                  cnt   <= '0;
                end
              end
              OP_INSERT: begin
                out_status  <= ins_st;
                out_element <= '0;
                m_tlast     <= 1'b1;
                out_empty   <= 1'b0;
                if (ins_st == ST_OK) begin
                  len <= len + ONE_L;
                end
              end
              OP_DELETE: begin
                out_status  <= del_st;
                out_element <= '0;
                m_tlast     <= 1'b1;
                out_empty   <= 1'b0;
                if (del_st == ST_OK) begin
                  len <= len - ONE_L;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_VIEW: begin
          if (view_step) begin
            out_status  <= ST_OK;
            out_element <= cells[0];
            m_tlast     <= view_last;
            out_empty   <= 1'b0;
            cnt         <= cnt + ONE_L;
            if (view_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, out_element, out_status};
  assign m_tuser = out_empty;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CAP_L)
    else $error("list length beyond capacity");

  a_view_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_VIEW) |-> !s_tready)
    else $error("request taken during view");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_op == OP_INSERT) && (ins_st == ST_OK)) |=>
      (len == $past(len) + ONE_L))
    else $error("insert did not grow list");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (out_status == ST_OK)))
    else $error("empty view result malformed");

  a_view_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_VIEW) |-> (cnt < len))
    else $error("view counter past length");

endmodule

// ===== tb/sv/pli_tb_pkg.sv =====
// Scoreboard for the positional list: mirrors the list and checks each result in order.
`timescale 1ns / 1ps
package pli_tb_pkg;
  import pli_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] element;
    logic             last;
    logic             empty_res;
  } list_result_t;

  class list_scoreboard;
    int               capacity;
    logic [VAL_W-1:0] cells[$];
    list_result_t     pending_results[$];
    int errors;
    int checked;
    int views;
    int inserts;
    int deletes;
    int ignored;
    int full_refusals;
    int range_refusals;
    int peak_length;

    function new(int capacity);
      this.capacity = capacity;
    endfunction

    function int length();
      return cells.size();
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [1:0] op, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] value);
      logic [ST_W-1:0] st;
      st = ST_OK;
      case (op)
        OP_VIEW: begin
          views++;
          if (cells.size() == 0) begin
            pending_results.push_back(list_result_t'{ST_OK, '0, 1'b1, 1'b1});
          end else begin
            foreach (cells[i]) begin
              pending_results.push_back(
                list_result_t'{ST_OK, cells[i], 1'(i == cells.size() - 1), 1'b0});
            end
          end
        end
        OP_INSERT: begin
          inserts++;
          if (pos > cells.size()) begin
            st = ST_RANGE;
          end else if (cells.size() >= capacity) begin
            st = ST_FULL;
          end else begin
            cells.insert(int'(pos), value);
          end
          pending_results.push_back(list_result_t'{st, '0, 1'b1, 1'b0});
        end
        OP_DELETE: begin
          deletes++;
          if (cells.size() == 0 || pos > cells.size()) begin
            st = ST_RANGE;
          end else begin
            cells.delete((pos == 0) ? 0 : int'(pos) - 1);
          end
          pending_results.push_back(list_result_t'{st, '0, 1'b1, 1'b0});
        end
        default: begin
          ignored++;
        end
      endcase
      if (st == ST_FULL) full_refusals++;
      if (st == ST_RANGE) range_refusals++;
      if (cells.size() > peak_length) peak_length = cells.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 25) $display("mismatch %0d: %s", errors, what);
    endtask

    task check_result(logic [ST_W-1:0] status, logic [VAL_W-1:0] element,
                      logic last, logic empty_res);
      list_result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d with nothing outstanding: status %0d element %0d",
                         checked, status, $signed(element)));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", checked, status, want.status));
      if (element !== want.element)
        report($sformatf("result %0d element %0d, want %0d", checked,
                         $signed(element), $signed(want.element)));
      if (last !== want.last)
        report($sformatf("result %0d last %b, want %b", checked, last, want.last));
      if (empty_res !== want.empty_res)
        report($sformatf("result %0d empty_res %b, want %b", checked, empty_res,
                         want.empty_res));
    endtask
  endclass

endpackage

// ===== tb/sv/tb_positional_list_insert_delete.sv =====
// Regression bench for the positional list: directed and random requests with stalls.
`timescale 1ns / 1ps
module tb_positional_list_insert_delete;
  import pli_pkg::*;
  import pli_tb_pkg::*;

  localparam int TARGET_REQUESTS = 480;
  localparam int IDLE_LIMIT      = 2000;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} rx_pattern_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_VIEW;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  list_scoreboard sb = new(CAPACITY_DEF);

  int          sent;
  int          burst_left = 1;
  int          idle_cycles;
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_window;
  int          rx_hold;

  positional_list_insert_delete #(
    .CAPACITY(CAPACITY_DEF)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata[1:0], m_tdata[33:2], m_tlast, m_tuser);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[5:0], s_tdata[37:6]);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, sb.outstanding());
        $display("positional_list_insert_delete regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    logic next_ready;
    if (rx_window == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(3));
      rx_window  <= $urandom_range(300, 50);
    end else begin
      rx_window <= rx_window - 1;
    end
    case (rx_pattern)
      RX_OPEN:     next_ready = 1'b1;
      RX_COIN:     next_ready = 1'($urandom_range(1));
      RX_PERIODIC: next_ready = (rx_window % 5) != 4;
      default: begin
        if (rx_hold == 0) begin
          next_ready = !m_tready;
          rx_hold    <= $urandom_range(9);
        end else begin
          next_ready = m_tready;
          rx_hold    <= rx_hold - 1;
        end
      end
    endcase
    m_tready <= next_ready;
  end

  // Hold the request until taken, then pause between bursts.
  task automatic send_request(logic [1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, value, pos};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op != OP_UNUSED) sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic random_request(int insert_pct, int delete_pct);
    int               roll;
    int               len;
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    len  = sb.length();
    roll = $urandom_range(99);
    if (roll < 2) op = OP_UNUSED;
    else if (roll < 2 + insert_pct) op = OP_INSERT;
    else if (roll < 2 + insert_pct + delete_pct) op = OP_DELETE;
    else op = OP_VIEW;
    roll = $urandom_range(99);
    if (roll < 80) pos = POS_W'($urandom_range(len));
    else if (roll < 92) pos = POS_W'($urandom_range(63, len + 1));
    else pos = POS_W'($urandom);
    case ($urandom_range(9))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = '0;
      3:       value = '1;
      default: value = $urandom;
    endcase
    send_request(op, pos, value);
  endtask

  initial begin
    int insert_pct;
    int delete_pct;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(OP_VIEW,   0,  '0);
    send_request(OP_DELETE, 0,  '0);
    send_request(OP_DELETE, 1,  '0);
    send_request(OP_INSERT, 1,  32'h1234_5678);
    send_request(OP_INSERT, 0,  32'h8000_0000);
    send_request(OP_INSERT, 1,  32'h7fff_ffff);
    send_request(OP_INSERT, 0,  32'h0000_0000);
    send_request(OP_INSERT, 3,  32'hffff_ffff);
    send_request(OP_INSERT, 2,  32'h5555_aaaa);
    send_request(OP_INSERT, 63, 32'haaaa_5555);
    send_request(OP_VIEW,   63, 32'hffff_ffff);
    send_request(OP_DELETE, 63, '0);
    send_request(OP_DELETE, 5,  '0);
    send_request(OP_DELETE, 5,  '0);
    send_request(OP_DELETE, 0,  '0);
    send_request(OP_DELETE, 1,  '0);
    send_request(OP_VIEW,   0,  '0);
    send_request(OP_UNUSED, 1,  32'hdead_beef);
    send_request(OP_VIEW,   0,  '0);
    send_request(OP_DELETE, 2,  '0);
    send_request(OP_DELETE, 1,  '0);
    send_request(OP_VIEW,   0,  '0);

    // Fill to capacity, then probe the full and beyond-length refusals.
    while (sb.length() < CAPACITY_DEF)
      send_request(OP_INSERT, POS_W'($urandom_range(sb.length())), $urandom);
    send_request(OP_INSERT, POS_W'($urandom_range(CAPACITY_DEF)), $urandom);
    send_request(OP_INSERT, POS_W'($urandom_range(63, CAPACITY_DEF + 1)), $urandom);
    send_request(OP_VIEW, 0, '0);
    send_request(OP_DELETE, POS_W'(CAPACITY_DEF), '0);

    while (sent < TARGET_REQUESTS) begin
      case ($urandom_range(3))
        0: begin insert_pct = 75; delete_pct = 10; end
        1: begin insert_pct = 40; delete_pct = 40; end
        2: begin insert_pct = 15; delete_pct = 70; end
        default: begin
          insert_pct = $urandom_range(80);
          delete_pct = $urandom_range(96 - insert_pct);
        end
      endcase
      repeat (40) random_request(insert_pct, delete_pct);
    end

    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d requests (%0d views, %0d inserts, %0d deletes, %0d ignored)",
             sent, sb.views, sb.inserts, sb.deletes, sb.ignored);
    $display("%0d results checked; list peaked at %0d of %0d; %0d full and %0d range refusals",
             sb.checked, sb.peak_length, CAPACITY_DEF, sb.full_refusals, sb.range_refusals);
    if (sb.errors == 0) begin
      $display("positional_list_insert_delete regression: pass");
    end else begin
      $display("positional_list_insert_delete regression: fail");
    end
    $finish;
  end

endmodule
